// ===== design/lsis_pkg.sv =====
// ----------------------------------------------------------------------------
// Lost-sales inventory step: shared definitions
// Widths, register map, status codes and result packing for the block.
// ----------------------------------------------------------------------------
package lsis_pkg;

  localparam int RING_DEPTH = 16;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int QTY_W      = 12;
  localparam int RATE_W     = 16;
  localparam int LEAD_W     = 4;
  localparam int COST_W     = 28;
  localparam int STATUS_W   = 2;

  localparam int CFG_AW     = 5;
  localparam int CFG_DW     = 32;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 64;

  localparam logic [2:0] REG_HOLDING_COST  = 3'd0;
  localparam logic [2:0] REG_LOST_PENALTY  = 3'd1;
  localparam logic [2:0] REG_LEAD_TIME     = 3'd2;
  localparam logic [2:0] REG_MAX_ORDER     = 3'd3;
  localparam logic [2:0] REG_MAX_SYSTEM    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TURN     = 2'd2;

  localparam logic FUNC_ORDER  = 1'b0;
  localparam logic FUNC_DEMAND = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [QTY_W-1:0] qty_t;

  typedef struct packed {
    qty_t              total_inventory;
    qty_t              leftover_units;
    qty_t              lost_units;
    logic [COST_W-1:0] period_cost;
  } result_t;

  // Ring index arithmetic that also holds for a depth that is not a power of two.
  function automatic idx_t ring_add(idx_t a, idx_t b);
    logic [IDX_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (IDX_W+1)'(RING_DEPTH)) begin
      sum = sum - (IDX_W+1)'(RING_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== design/lost_sales_inventory_step.sv =====
// ----------------------------------------------------------------------------
// Lost-sales inventory step
// Order and demand processing over a delivery ring held in a small memory.
// ----------------------------------------------------------------------------
// Each input transaction is an order (tuser 0) or a demand (tuser 1) and
// yields exactly one result transaction. In the cycle an item is accepted
// the delivery ring memory is read at the slots it needs, and in the
// next cycle the result is computed and the ring, its valid bits and
// the totals are written back, so no new item is accepted while one is
// being computed, nor while the output register holds a result not yet
// taken. The ring is cleared at reset through per-slot valid bits, so
// the block is ready at once. Reset the block after changing the lead time.
module lost_sales_inventory_step
  import lsis_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // quantity[11:0], zero fill
  input  logic                  in_tuser,   // func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // period_cost, lost_units, leftover_units,
                                            // total_inventory
  output logic [STATUS_W-1:0]   out_tuser,  // status
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  logic [RATE_W-1:0] holding_cost_r;
  logic [RATE_W-1:0] lost_penalty_r;
  logic [LEAD_W-1:0] lead_time_r;
  qty_t              max_order_r;
  qty_t              max_system_r;

  logic [2:0] cfg_idx;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holding_cost_r <= RATE_W'(256);
      lost_penalty_r <= RATE_W'(2304);
      lead_time_r    <= LEAD_W'(2);
      max_order_r    <= QTY_W'(4095);
      max_system_r   <= QTY_W'(4095);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_HOLDING_COST: holding_cost_r <= cfg_pwdata[RATE_W-1:0];
        REG_LOST_PENALTY: lost_penalty_r <= cfg_pwdata[RATE_W-1:0];
        REG_LEAD_TIME:    lead_time_r    <= cfg_pwdata[LEAD_W-1:0];
        REG_MAX_ORDER:    max_order_r    <= cfg_pwdata[QTY_W-1:0];
        REG_MAX_SYSTEM:   max_system_r   <= cfg_pwdata[QTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_HOLDING_COST: cfg_prdata = CFG_DW'(holding_cost_r);
      REG_LOST_PENALTY: cfg_prdata = CFG_DW'(lost_penalty_r);
      REG_LEAD_TIME:    cfg_prdata = CFG_DW'(lead_time_r);
      REG_MAX_ORDER:    cfg_prdata = CFG_DW'(max_order_r);
      REG_MAX_SYSTEM:   cfg_prdata = CFG_DW'(max_system_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // Effective lead time: zero counts as one slot, and it never reaches the ring depth.
  idx_t eff_lead;
  always_comb begin
    if (lead_time_r == '0) begin
      eff_lead = idx_t'(1);
    end else if (32'(lead_time_r) > RING_DEPTH - 1) begin
      eff_lead = idx_t'(RING_DEPTH - 1);
    end else begin
      eff_lead = idx_t'(lead_time_r);
    end
  end

  qty_t                mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] slot_valid_r;
  logic [RING_DEPTH-1:0] slot_valid_nxt;

  idx_t head_r, head_nxt;
  qty_t total_r, total_nxt;
  logic await_r, await_nxt;
  logic busy_r;

  logic func_r;
  qty_t qty_r;
  idx_t addr_a_r, addr_b_r;
  qty_t rd_a_r, rd_b_r;

  logic in_acc;
  idx_t addr_a, addr_b;

  logic out_valid_r;
  result_t out_res_r, out_res_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  assign in_tready = !busy_r && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign addr_b    = ring_add(head_r, idx_t'(1));
  assign addr_a    = (in_tuser == FUNC_ORDER) ? ring_add(head_r, eff_lead) : head_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_a_r   <= mem[addr_a];
      rd_b_r   <= mem[addr_b];
      addr_a_r <= addr_a;
      addr_b_r <= addr_b;
      func_r   <= in_tuser;
      qty_r    <= in_tdata[QTY_W-1:0];
    end
  end

  qty_t              on_hand, next_val;
  logic [QTY_W:0]    order_sum;
  qty_t              left_units, lost_units;
  logic [COST_W-1:0] cost;
  logic              wr_en;
  idx_t              wr_addr;
  qty_t              wr_data;

  always_comb begin
    on_hand        = slot_valid_r[addr_a_r] ? rd_a_r : '0;
    next_val       = slot_valid_r[addr_b_r] ? rd_b_r : '0;
    order_sum      = {1'b0, total_r} + {1'b0, qty_r};
    left_units     = '0;
    lost_units     = '0;
    cost           = '0;
    wr_en          = 1'b0;
    wr_addr        = addr_a_r;
    wr_data        = on_hand + qty_r;
    slot_valid_nxt = slot_valid_r;
    head_nxt       = head_r;
    total_nxt      = total_r;
    await_nxt      = await_r;
    out_status_nxt = ST_DONE;

    if (func_r == FUNC_ORDER) begin
      if (await_r) begin
        out_status_nxt = ST_TURN;
      end else if (qty_r == '0 ||
                   (order_sum <= {1'b0, max_system_r} && qty_r <= max_order_r)) begin
        wr_en                    = 1'b1;
        slot_valid_nxt[addr_a_r] = 1'b1;
        total_nxt                = order_sum[QTY_W-1:0];
        await_nxt                = 1'b1;
      end else begin
        out_status_nxt = ST_REJECTED;
      end
    end else begin
      if (!await_r) begin
        out_status_nxt = ST_TURN;
      end else begin
        slot_valid_nxt[addr_a_r] = 1'b0;
        head_nxt                 = addr_b_r;
        await_nxt                = 1'b0;
        if (on_hand > qty_r) begin
          left_units               = on_hand - qty_r;
          total_nxt                = (total_r >= qty_r) ? total_r - qty_r : '0;
          wr_en                    = 1'b1;
          wr_addr                  = addr_b_r;
          wr_data                  = next_val + left_units;
          slot_valid_nxt[addr_b_r] = 1'b1;
          cost                     = COST_W'(left_units * holding_cost_r);
        end else begin
          lost_units = qty_r - on_hand;
          total_nxt  = (total_r >= on_hand) ? total_r - on_hand : '0;
          cost       = COST_W'(lost_units * lost_penalty_r);
        end
      end
    end

    out_res_nxt.period_cost     = cost;
    out_res_nxt.lost_units      = lost_units;
    out_res_nxt.leftover_units  = left_units;
    out_res_nxt.total_inventory = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (busy_r && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      head_r       <= '0;
      total_r      <= '0;
      await_r      <= 1'b0;
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r <= in_acc;
      if (busy_r) begin
        slot_valid_r <= slot_valid_nxt;
        head_r       <= head_nxt;
        total_r      <= total_nxt;
        await_r      <= await_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      out_res_r    <= out_res_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_res_r);
  assign out_tuser  = out_status_r;

endmodule

// ===== design/lsis_checker.sv =====
// ----------------------------------------------------------------------------
// Lost-sales inventory step: port checker
// Concurrent checks on the channel behaviour seen at the top-level ports.
// ----------------------------------------------------------------------------
module lsis_checker
  import lsis_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [STATUS_W-1:0]   out_tuser
);

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##2 out_tvalid)
    else $error("no result two cycles after an input transaction");

  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input taken in the cycle after a transaction");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= ST_TURN)
    else $error("undefined status code");

  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_DONE |-> out_tdata[51:0] == '0)
    else $error("cost or unit fields set on a rejected or out-of-turn item");

endmodule

bind lost_sales_inventory_step lsis_checker u_lsis_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
